/* rtl/ppsp_pkg.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser package
// Shared types, character codes and helper functions for the parser blocks.
// ----------------------------------------------------------------------------
package ppsp_pkg;

	// Largest accepted image dimension, capped so that it fits 13 bits.
	localparam int MAX_DIM = 4096;
	localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
	localparam logic [15:0] DIM_LIMIT = 16'(DIM_CAP);
	localparam logic [15:0] MAXVAL_REQ = 16'd255;

	// Character codes used by the header grammar.
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_SIX  = 8'h36;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Parse phases.
	typedef enum logic [3:0] {
		PH_MAGIC0 = 4'd0,
		PH_MAGIC1 = 4'd1,
		PH_PRE_W  = 4'd2,
		PH_NUM_W  = 4'd3,
		PH_PRE_H  = 4'd4,
		PH_NUM_H  = 4'd5,
		PH_PRE_M  = 4'd6,
		PH_NUM_M  = 4'd7,
		PH_PIXELS = 4'd8,
		PH_HALT   = 4'd9
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// Error codes.
	typedef enum logic [2:0] {
		ERR_MAGIC      = 3'd0,
		ERR_WIDTH      = 3'd1,
		ERR_HEIGHT     = 3'd2,
		ERR_MAXVAL_DIG = 3'd3,
		ERR_MAXVAL_VAL = 3'd4
	} err_code_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	// One result item with its valid flag.
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		err_code_t   error_code;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last_pixel;
	} result_t;

	function automatic logic is_space(input logic [7:0] b);
		return b inside {CH_SP, CH_TAB, CH_CR, CH_LF};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[CH_ZERO:CH_NINE]};
	endfunction

	// Accumulator times ten plus the digit, kept wide enough to see overflow.
	function automatic logic [19:0] mul10_add(input logic [15:0] acc, input logic [7:0] b);
		return {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, b[3:0]};
	endfunction

endpackage

/* rtl/ppsp_in_if.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser input channel
// Valid/ready channel carrying one file byte and its start-of-file mark.
// ----------------------------------------------------------------------------
interface ppsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

/* rtl/ppsp_out_if.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser output channel
// Valid/ready channel carrying one header, pixel or error item.
// ----------------------------------------------------------------------------
interface ppsp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  error_code;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last_pixel;

	modport source (output valid, output kind, output error_code, output image_width,
		output image_height, output red, output green, output blue, output last_pixel,
		input ready);
	modport sink (input valid, input kind, input error_code, input image_width,
		input image_height, input red, input green, input blue, input last_pixel,
		output ready);
endinterface

/* rtl/ppsp_in_stage.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser input register
// Registers each accepted byte; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module ppsp_in_stage
	import ppsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ppsp_in_if.sink   in_ch,
	input  logic      consume,
	output logic      valid,
	output in_item_t  item
);

	logic     valid_s1;
	in_item_t item_s1;

	// Take a new item whenever the register is empty or being drained.
	assign in_ch.ready = !valid_s1 || consume;
	assign valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= '{data_byte: in_ch.data_byte, file_start: in_ch.file_start};
		end
	end

endmodule

/* rtl/ppsp_parser.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser core
// Header grammar, number accumulation and pixel grouping, one byte per step.
// ----------------------------------------------------------------------------
module ppsp_parser
	import ppsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output result_t  res
);

	phase_t      phase_q, phase_d, ph;
	logic        comment_q, comment_d, cur_comment;
	logic [15:0] acc_q, acc_d, cur_acc;
	logic        seen_q, seen_d, cur_seen;
	logic        ovf_q, ovf_d, cur_ovf;
	logic [12:0] width_q, width_d, cur_width;
	logic [12:0] height_q, height_d, cur_height;
	logic [12:0] column_q, column_d, cur_column;
	logic [12:0] row_q, row_d, cur_row;
	logic [1:0]  bphase_q, bphase_d, cur_bphase;
	logic [7:0]  red_q, red_d, cur_red;
	logic [7:0]  green_q, green_d, cur_green;

	logic [7:0]  b;
	logic [19:0] acc_next;
	logic        b_digit, b_space, b_eol;

	assign b = item.data_byte;
	assign b_digit = is_digit(b);
	assign b_space = is_space(b);
	assign b_eol = (b == CH_LF) || (b == CH_CR);

	// A start-of-file byte sees the reset state, whatever came before.
	always_comb begin
		if (item.file_start) begin
			ph = PH_MAGIC0;
			cur_comment = 1'b0;
			cur_acc = '0;
			cur_seen = 1'b0;
			cur_ovf = 1'b0;
			cur_width = '0;
			cur_height = '0;
			cur_column = '0;
			cur_row = '0;
			cur_bphase = '0;
			cur_red = '0;
			cur_green = '0;
		end else begin
			ph = phase_q;
			cur_comment = comment_q;
			cur_acc = acc_q;
			cur_seen = seen_q;
			cur_ovf = ovf_q;
			cur_width = width_q;
			cur_height = height_q;
			cur_column = column_q;
			cur_row = row_q;
			cur_bphase = bphase_q;
			cur_red = red_q;
			cur_green = green_q;
		end
	end

	assign acc_next = mul10_add(cur_acc, b);

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_d = ph;
		comment_d = cur_comment;
		acc_d = cur_acc;
		seen_d = cur_seen;
		ovf_d = cur_ovf;
		width_d = cur_width;
		height_d = cur_height;
		column_d = cur_column;
		row_d = cur_row;
		bphase_d = cur_bphase;
		red_d = cur_red;
		green_d = cur_green;
		res = '0;

		if (cur_comment) begin
			// Comments run to the end of the line.
			if (b_eol) begin
				comment_d = 1'b0;
			end
		end else begin
			case (ph)
				PH_MAGIC0: begin
					if (b != CH_P) begin
						res.valid = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_MAGIC;
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_MAGIC1;
					end
				end
				PH_MAGIC1: begin
					if (b != CH_SIX) begin
						res.valid = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_MAGIC;
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_PRE_W;
					end
				end
				PH_PRE_W, PH_PRE_H, PH_PRE_M: begin
					// Skip separators until the first digit of the next number.
					if (b == CH_HASH) begin
						comment_d = 1'b1;
					end else if (b_digit) begin
						acc_d = {12'd0, b[3:0]};
						seen_d = 1'b1;
						ovf_d = 1'b0;
						phase_d = phase_t'(ph + 4'd1);
					end else if (!b_space) begin
						res.valid = 1'b1;
						res.kind = KIND_ERROR;
						case (ph)
							PH_PRE_W: res.error_code = ERR_WIDTH;
							PH_PRE_H: res.error_code = ERR_HEIGHT;
							default:  res.error_code = ERR_MAXVAL_DIG;
						endcase
						phase_d = PH_HALT;
					end
				end
				PH_NUM_W, PH_NUM_H: begin
					if (b_digit) begin
						acc_d = acc_next[15:0];
						ovf_d = cur_ovf || (acc_next[19:16] != 4'd0);
						seen_d = 1'b1;
					end else if ((!b_space && b != CH_HASH) || cur_ovf ||
							(cur_acc > DIM_LIMIT)) begin
						res.valid = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = (ph == PH_NUM_W) ? ERR_WIDTH : ERR_HEIGHT;
						phase_d = PH_HALT;
					end else begin
						if (ph == PH_NUM_W) begin
							width_d = cur_acc[12:0];
						end else begin
							height_d = cur_acc[12:0];
						end
						acc_d = '0;
						seen_d = 1'b0;
						ovf_d = 1'b0;
						comment_d = (b == CH_HASH);
						phase_d = phase_t'(ph + 4'd1);
					end
				end
				PH_NUM_M: begin
					if (b_digit) begin
						acc_d = acc_next[15:0];
						ovf_d = cur_ovf || (acc_next[19:16] != 4'd0);
						seen_d = 1'b1;
					end else if (!b_space) begin
						res.valid = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_MAXVAL_DIG;
						phase_d = PH_HALT;
					end else if (cur_ovf || cur_acc != MAXVAL_REQ) begin
						res.valid = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_MAXVAL_VAL;
						phase_d = PH_HALT;
					end else begin
						// Header complete: report it and start on the pixels, or halt if the image is empty.
						acc_d = '0;
						seen_d = 1'b0;
						ovf_d = 1'b0;
						res.valid = 1'b1;
						res.kind = KIND_HEADER;
						res.image_width = cur_width;
						res.image_height = cur_height;
						column_d = '0;
						row_d = '0;
						bphase_d = '0;
						if (cur_width == '0 || cur_height == '0) begin
							res.last_pixel = 1'b1;
							phase_d = PH_HALT;
						end else begin
							phase_d = PH_PIXELS;
						end
					end
				end
				PH_PIXELS: begin
					// Gather red and green, emit the pixel on blue.
					if (cur_bphase == 2'd0) begin
						red_d = b;
						bphase_d = 2'd1;
					end else if (cur_bphase == 2'd1) begin
						green_d = b;
						bphase_d = 2'd2;
					end else begin
						bphase_d = 2'd0;
						res.valid = 1'b1;
						res.kind = KIND_PIXEL;
						res.red = cur_red;
						res.green = cur_green;
						res.blue = b;
						if ({1'b0, cur_column} + 14'd1 >= {1'b0, cur_width}) begin
							column_d = '0;
							if ({1'b0, cur_row} + 14'd1 >= {1'b0, cur_height}) begin
								res.last_pixel = 1'b1;
								phase_d = PH_HALT;
							end else begin
								row_d = cur_row + 13'd1;
							end
						end else begin
							column_d = cur_column + 13'd1;
						end
					end
				end
				default: begin
				end
			endcase
			if (res.valid && res.kind == KIND_ERROR) begin
				comment_d = 1'b0;
			end
		end
	end

	// Parse state registers, updated once per consumed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC0;
			comment_q <= 1'b0;
			acc_q <= '0;
			seen_q <= 1'b0;
			ovf_q <= 1'b0;
			width_q <= '0;
			height_q <= '0;
			column_q <= '0;
			row_q <= '0;
			bphase_q <= '0;
			red_q <= '0;
			green_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			comment_q <= comment_d;
			acc_q <= acc_d;
			seen_q <= seen_d;
			ovf_q <= ovf_d;
			width_q <= width_d;
			height_q <= height_d;
			column_q <= column_d;
			row_q <= row_d;
			bphase_q <= bphase_d;
			red_q <= red_d;
			green_q <= green_d;
		end
	end

	// An error always parks the parser until the next file.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.kind == KIND_ERROR |=> phase_q == PH_HALT)
		else $error("error item did not halt the parser");

	// Pixels come only out of the pixel phase of the current file.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.kind == KIND_PIXEL |-> phase_q == PH_PIXELS && !item.file_start)
		else $error("pixel item outside the pixel phase");

	// Raster counters stay inside the image while pixels are expected.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> column_q < width_q && row_q < height_q)
		else $error("raster counter beyond image size");

	// A stored width or height never exceeds the dimension limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> {3'd0, width_q} <= DIM_LIMIT && {3'd0, height_q} <= DIM_LIMIT)
		else $error("stored dimension above limit");

endmodule

/* rtl/ppsp_out_stage.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ppsp_out_stage
	import ppsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       can_take,
	ppsp_out_if.source out_ch
);

	logic    valid_q;
	result_t res_q;

	// The register is free when empty or being emptied this cycle.
	assign can_take = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			res_q <= res;
		end
	end

	// Drive the channel from the held item.
	assign out_ch.valid = valid_q;
	assign out_ch.kind = res_q.kind;
	assign out_ch.error_code = res_q.error_code;
	assign out_ch.image_width = res_q.image_width;
	assign out_ch.image_height = res_q.image_height;
	assign out_ch.red = res_q.red;
	assign out_ch.green = res_q.green;
	assign out_ch.blue = res_q.blue;
	assign out_ch.last_pixel = res_q.last_pixel;

endmodule

/* rtl/ppsp_out_stage_note.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser consume control
// Decides when the byte in the input register is processed.
// ----------------------------------------------------------------------------
module ppsp_step_ctrl
	import ppsp_pkg::*;
(
	input  logic    in_valid,
	input  logic    out_can_take,
	input  result_t res,
	output logic    step,
	output logic    load
);

	// A byte is processed only when the result register has a free slot, whether or not it yields a result.
	assign step = in_valid && out_can_take;
	assign load = step && res.valid;

endmodule

/* rtl/ppm_p6_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser
// Parses a binary PPM byte stream into a header item and RGB pixel items, or an error item.
// ----------------------------------------------------------------------------
// Usage:
// in_ch carries one file byte per item with file_start marking the first
// byte of a new file. out_ch carries header, pixel or error items; the kind
// field says which, and last_pixel marks the final pixel of the image.
// An accepted byte is registered in the input register and processed once
// the result register is free; its result (if it causes one) is loaded into
// the result register at the end of the cycle in which it is processed.
// Throughput is one byte per cycle while the receiver takes results; the parse
// update between the input register and the result register is combinational.
// When the receiver stalls, the result register holds its item and one more
// byte waits in the input register; in_ch.ready then falls.
// Reset clears both registers and puts the parser in wait for the magic, so
// a file may begin without file_start. After an error or the end of an image
// bytes are consumed without result until the next file_start.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser_unit
	import ppsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ppsp_in_if.sink    in_ch,
	ppsp_out_if.source out_ch
);

	logic     in_valid;
	in_item_t item;
	logic     step;
	logic     load;
	logic     out_can_take;
	result_t  res;

	ppsp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.consume (step),
		.valid   (in_valid),
		.item    (item)
	);

	ppsp_step_ctrl u_step_ctrl (
		.in_valid     (in_valid),
		.out_can_take (out_can_take),
		.res          (res),
		.step         (step),
		.load         (load)
	);

	ppsp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item),
		.res    (res)
	);

	ppsp_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.can_take (out_can_take),
		.out_ch   (out_ch)
	);

endmodule
